// ----- hw/rtl/pdec_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdec_pkg
// Shared types, constants and helpers for the percent decoder.
// ----------------------------------------------------------------------------
package pdec_pkg;

  // Escape introducer
  localparam logic [7:0] PCT_CHAR = 8'h25;

  // Largest number of decoded bytes one input beat can produce
  localparam int MAX_RES = 3;

  // Default depth of the bundle queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Decoded bytes produced by one input beat
  typedef struct packed {
    logic [1:0]              cnt;    // number of valid bytes, 1..3
    logic [MAX_RES-1:0][7:0] bytes;  // bytes[0] goes out first
    logic                    last;   // final bundle of the string
  } bundle_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Hex digit decode: {valid, nibble}; nibble is zero when not a digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pdec_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdec_front
// Accepts raw bytes, tracks pending escapes and builds one bundle of decoded
// bytes per input beat.
// ----------------------------------------------------------------------------
module pdec_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  input  pdec_pkg::q_status_t    q_status,
  output logic                   push,
  output pdec_pkg::bundle_t      push_data
);

  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic       accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  // Scanner: next held state and the bytes this beat releases
  always_comb begin
    logic [4:0]                        hv;
    logic [4:0]                        hi;
    logic [1:0]                        n;
    logic [pdec_pkg::MAX_RES-1:0][7:0] o;
    logic                              fresh;
    hv           = pdec_pkg::hex_decode(in_byte);
    hi           = pdec_pkg::hex_decode(held1_r);
    n            = 2'd0;
    o            = '0;
    fresh        = 1'b0;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = 2'd0;

    unique case (held_cnt_r)
      2'd1: begin
        if (hv[4]) begin
          held1_nxt    = in_byte;
          held_cnt_nxt = 2'd2;
        end else begin
          o[0]  = held0_r;
          n     = 2'd1;
          fresh = 1'b1;
        end
      end
      2'd2: begin
        if (hv[4]) begin
          o[0] = {hi[3:0], hv[3:0]};
          n    = 2'd1;
        end else begin
          o[0]  = held0_r;
          o[1]  = held1_r;
          n     = 2'd2;
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // Fresh scan with nothing held
    if (fresh) begin
      if (in_byte == pdec_pkg::PCT_CHAR) begin
        held0_nxt    = in_byte;
        held_cnt_nxt = 2'd1;
      end else if (n != 2'd3) begin
        o[n] = in_byte;
        n    = n + 2'd1;
      end
    end

    // End of string: flush whatever is still held
    if (in_last) begin
      if (held_cnt_nxt != 2'd0 && n != 2'd3) begin
        o[n] = held0_nxt;
        n    = n + 2'd1;
      end
      if (held_cnt_nxt == 2'd2 && n != 2'd3) begin
        o[n] = held1_nxt;
        n    = n + 2'd1;
      end
      held0_nxt    = 8'd0;
      held1_nxt    = 8'd0;
      held_cnt_nxt = 2'd0;
    end

    push_data.cnt   = n;
    push_data.bytes = o;
    push_data.last  = in_last;
    push            = accept && (n != 2'd0);
  end

  // Held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held0_r    <= 8'd0;
      held1_r    <= 8'd0;
      held_cnt_r <= 2'd0;
    end else if (accept) begin
      held0_r    <= held0_nxt;
      held1_r    <= held1_nxt;
      held_cnt_r <= held_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pdec_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdec_queue
// Small register FIFO of bundles between the front and back parts.
// ----------------------------------------------------------------------------
module pdec_queue #(
  parameter int Depth = pdec_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  pdec_pkg::bundle_t      push_data,
  input  wire logic              pop,
  output pdec_pkg::bundle_t      head,
  output pdec_pkg::q_status_t    q_status
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  pdec_pkg::bundle_t entry_r [Depth];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign q_status.full  = (count_r == FULL_CNT);
  assign q_status.empty = (count_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = entry_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pdec_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdec_back
// Drains bundles one byte per beat into the registered output stage.
// ----------------------------------------------------------------------------
module pdec_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  pdec_pkg::bundle_t      head,
  input  pdec_pkg::q_status_t    q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] idx_r;
  logic       load;
  logic       at_end;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // Load a byte when the output stage is free or being taken
  assign load   = !q_status.empty && (!out_valid_r || !out_stall);
  assign at_end = (idx_r == head.cnt - 2'd1);
  assign pop    = load && at_end;

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head.bytes[idx_r];
      out_last_r <= head.last && at_end;
    end
  end

  // Output valid and byte index within the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/percent_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// percent_decoder_core
// Streaming URL percent decoder with a front scanner and a back drainer.
// ----------------------------------------------------------------------------
// The block takes one encoded byte per cycle while in_stall is low and returns
// one decoded byte per cycle while out_stall is low. Each input beat is turned
// by the front scanner into a bundle of zero to three output bytes; a '%' and
// its first digit are held back until the escape resolves or the string ends.
// Bundles wait in a QueueDepth-entry queue and the back part sends their bytes
// out one per cycle, unless the output stalls, through a registered output
// stage, so the first byte of a beat passes through a queue entry and then the
// output register. Input stalls only while the queue is full, which happens
// when beats that release two or three bytes (a failed escape or a flush at
// the end of a string) arrive faster than the one-byte-per-cycle output
// drains them, or while the output side stalls.
module percent_decoder_core #(
  parameter int QueueDepth = pdec_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  pdec_pkg::q_status_t q_status;
  pdec_pkg::bundle_t   push_data;
  pdec_pkg::bundle_t   head;
  logic                push;
  logic                pop;

  // Scanner
  pdec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Bundle queue
  pdec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // Output drainer
  pdec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/pdec_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdec_checker
// Port-level checks for percent_decoder_core, attached by bind.
// ----------------------------------------------------------------------------
module pdec_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_byte,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output beat changed while stalled");

  // A stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("input beat changed while stalled");

  // Output stage is empty after reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Queue is empty after reset, so input is open
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // An output beat never comes out of a reset cycle
  a_no_out_in_rst: assert property (@(posedge clk)
    !rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid while held in reset");

endmodule

bind percent_decoder_core pdec_checker u_pdec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_byte   (in_byte),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
`default_nettype wire

// ----- test/tb_percent_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_percent_decoder_core
// Self-checking bench for the streaming percent decoder. A clocked driver
// offers encoded bytes from a queue. A predictor decodes every accepted beat
// into the bytes the block should return. A clocked monitor checks each
// returned beat against the oldest expected byte. Both sides idle and stall
// at random, with one calm stretch, one long output hold-off and two drain
// pauses on the input side.
// ----------------------------------------------------------------------------
module tb_percent_decoder_core;

  localparam int NO_DIGIT    = -1;
  localparam int IDLE_PCT    = 34;
  localparam int CALM_START  = 500;   // cycles with no random idling
  localparam int CALM_END    = 800;
  localparam int HOLD_AT     = 150;   // long output hold-off
  localparam int HOLD_CYCLES = 120;
  localparam int RANDOM_BYTES = 480;
  localparam int MAX_REPORTS = 10;

  // One encoded input byte; drain_first holds it back until all output is in
  typedef struct {
    logic [7:0] code;
    logic       fin;
    bit         drain_first;
  } enc_item_t;

  // One decoded output byte
  typedef struct {
    logic [7:0] code;
    logic       fin;
  } dec_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  enc_item_t enc_q[$];
  dec_item_t decoded_q[$];
  enc_item_t next_enc;
  dec_item_t want;

  // Predictor copy of the escape state
  logic [7:0]  pend_bytes [2] = '{8'h00, 8'h00};
  int unsigned pend_n = 0;
  int unsigned beat_results;

  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  bit          sync_next = 1'b0;
  bit          calm;

  percent_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return NO_DIGIT;
  endfunction

  task automatic put_decoded(input logic [7:0] c);
    dec_item_t d;
    d.code = c;
    d.fin  = 1'b0;
    decoded_q.push_back(d);
    beat_results++;
  endtask

  task automatic scan_idle(input logic [7:0] c);
    if (c == pdec_pkg::PCT_CHAR) begin
      pend_bytes[0] = c;
      pend_n = 1;
    end else begin
      put_decoded(c);
    end
  endtask

  task automatic scan_byte(input logic [7:0] c);
    int lo;
    int hi;
    lo = digit_of(c);
    case (pend_n)
      1: begin
        if (lo != NO_DIGIT) begin
          pend_bytes[1] = c;
          pend_n = 2;
        end else begin
          pend_n = 0;
          put_decoded(pend_bytes[0]);
          scan_idle(c);
        end
      end
      2: begin
        pend_n = 0;
        if (lo != NO_DIGIT) begin
          hi = digit_of(pend_bytes[1]);
          if (hi == NO_DIGIT) hi = 0;
          put_decoded(8'((hi << 4) | lo));
        end else begin
          put_decoded(pend_bytes[0]);
          put_decoded(pend_bytes[1]);
          scan_idle(c);
        end
      end
      default: begin
        pend_n = 0;
        scan_idle(c);
      end
    endcase
  endtask

  // Expected output for one accepted input beat
  task automatic decode_beat(input logic [7:0] c, input logic fin);
    beat_results = 0;
    scan_byte(c);
    if (fin) begin
      // flush whatever is still held back, raw
      for (int i = 0; i < int'(pend_n); i++) put_decoded(pend_bytes[i]);
      pend_n = 0;
      pend_bytes[0] = 8'h00;
      pend_bytes[1] = 8'h00;
      if (beat_results > 0) decoded_q[decoded_q.size() - 1].fin = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_hex();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'(8'h30 + k);
    if (k < 16) return 8'(8'h41 + k - 10);
    return 8'(8'h61 + k - 16);
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return pdec_pkg::PCT_CHAR;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (digit_of(c) != NO_DIGIT);
    return c;
  endfunction

  task automatic add_byte(input logic [7:0] c, input logic fin);
    enc_item_t e;
    e.code = c;
    e.fin = fin;
    e.drain_first = sync_next;
    sync_next = 1'b0;
    enc_q.push_back(e);
  endtask

  task automatic add_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], fin && (i == s.len() - 1));
  endtask

  // One string built from escapes, raw bytes and broken escapes; a few are noise
  task automatic add_random_string();
    logic [7:0] s[$];
    int ntok;
    int kind;
    if ($urandom_range(0, 9) == 0) begin
      ntok = $urandom_range(1, 8);
      repeat (ntok) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      ntok = $urandom_range(1, 6);
      repeat (ntok) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          s.push_back(pdec_pkg::PCT_CHAR);
          s.push_back(rand_hex());
          s.push_back(rand_hex());
        end else if (kind < 65) begin
          s.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 75) begin
          s.push_back(pdec_pkg::PCT_CHAR);
          s.push_back(rand_nonhex());
        end else if (kind < 85) begin
          s.push_back(pdec_pkg::PCT_CHAR);
          s.push_back(rand_hex());
          s.push_back(rand_nonhex());
        end else if (kind < 95) begin
          s.push_back(pdec_pkg::PCT_CHAR);
        end else begin
          s.push_back(rand_hex());
        end
      end
    end
    for (int i = 0; i < s.size(); i++) add_byte(s[i], i == s.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_beat(in_byte, in_last);
      if (in_valid && in_stall) begin
        // stalled beat stays as it is
      end else if (enc_q.size() != 0
                   && !(enc_q[0].drain_first && decoded_q.size() != 0)
                   && !(!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
        next_enc = enc_q.pop_front();
        in_byte  <= next_enc.code;
        in_last  <= next_enc.fin;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stall: random, plus one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (cyc == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Output monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < MAX_REPORTS)
          $display("unexpected beat: byte=%02h last=%0b", out_byte, out_last);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.code || out_last !== want.fin) begin
          errors <= errors + 1;
          if (errors < MAX_REPORTS)
            $display("bad beat: expected byte=%02h last=%0b, got byte=%02h last=%0b",
                     want.code, want.fin, out_byte, out_last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // valid escape, extremes of the escape value and of raw bytes
    add_text("%41", 1'b1);
    add_text("%ff%00", 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    // bad first digit, bad second digit
    add_text("%G", 1'b1);
    add_text("%9:", 1'b1);
    // bad second digit that starts a new escape
    add_text("%F%4a", 1'b1);
    // final byte with one and with two bytes held back
    add_text("%", 1'b1);
    add_text("%a", 1'b1);

    // let everything drain before the random part starts
    sync_next = 1'b1;
    while (enc_q.size() < RANDOM_BYTES / 2) add_random_string();
    sync_next = 1'b1;
    while (enc_q.size() < RANDOM_BYTES + 24) add_random_string();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (enc_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("percent_decoder_core: match");
    end else begin
      $display("percent_decoder_core: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("percent_decoder_core: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/pdec_pkg.sv
hw/rtl/pdec_front.sv
hw/rtl/pdec_queue.sv
hw/rtl/pdec_back.sv
hw/rtl/percent_decoder_core.sv
hw/rtl/pdec_checker.sv
test/tb_percent_decoder_core.sv
